### design/tfa_pkg.sv
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared codes, defaults and controller/datapath interface types of the
// template flux accumulator.
// ----------------------------------------------------------------------------
package tfa_pkg;

	localparam int SNAPS_DEF          = 8;
	localparam int BANDS_DEF          = 16;
	localparam int MAX_ROWS_DEF       = 64;
	localparam int TEMPLATE_DEPTH_DEF = 65536;

	// item commands
	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_LOAD  = 3'd1;
	localparam logic [2:0] CMD_BURST = 3'd2;
	localparam logic [2:0] CMD_MERGE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// table selects
	localparam logic [2:0] SEL_AGE    = 3'd0;
	localparam logic [2:0] SEL_INSP   = 3'd1;
	localparam logic [2:0] SEL_OUTSP  = 3'd2;
	localparam logic [2:0] SEL_TARGET = 3'd3;
	localparam logic [2:0] SEL_CLOUD  = 3'd4;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MIN_ROW   = 2'd0;
	localparam logic [1:0] CFG_MAX_ROW   = 2'd1;
	localparam logic [1:0] CFG_ROW_COUNT = 2'd2;
	localparam logic [1:0] CFG_FLOOR     = 2'd3;

	// metallicity to row: trunc(metals * 1000 - 0.5) on Q0.24
	localparam logic [33:0] METAL_SCALE = 34'd1000;
	localparam logic [33:0] HALF_Q24    = 34'd8388608;

	typedef struct packed {
		logic latch;
		logic exec;       // clear or load in the decode cycle
		logic row_calc;
		logic clamp;
		logic snap_fetch;
		logic addr_calc;
		logic band_rd;
		logic band_mul;
		logic band_acc;
		logic snap_next;
		logic flux_rd;
		logic merge_acc;
		logic read_cap;
		logic publish;
	} tfa_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       elem_ok;
		logic       used;
		logic       last_band;
		logic       last_snap;
		logic       out_free;
	} tfa_sts_t;

endpackage

### design/template_flux_accumulator.sv
// ----------------------------------------------------------------------------
// template_flux_accumulator
// Inside-cloud and outside-cloud flux accumulators of one galaxy, fed by
// clear, table load, burst, merge and read items.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid / in_stall with command, table_select, address,
//   load_value, snapshot, metals, rate, merge_in, merge_out; one item at a time.
//   output channel: out_valid / out_stall with status, in_value, out_value;
//   exactly one result per item, held in an output register.
//   configuration: cfg_we, cfg_index, cfg_data, written while idle.
// Sequencing:
//   clear, load and unused codes go from decode to the result; merge and read
//   read the flux memories first when the address is in range; a burst runs
//   the read, multiply and accumulate steps per band of each used snapshot.
//   A new item is taken in the cycle after a result enters the output register.
// Reset: all accumulators read as 1 (valid bits cleared), registers take
//   their reset values, tables hold nothing until loaded.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile and its result waits until the register frees.
// Template and special table depths must be powers of two.
// ----------------------------------------------------------------------------
module template_flux_accumulator
	import tfa_pkg::*;
#(
	parameter int SNAPS          = SNAPS_DEF,
	parameter int BANDS          = BANDS_DEF,
	parameter int MAX_ROWS       = MAX_ROWS_DEF,
	parameter int TEMPLATE_DEPTH = TEMPLATE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [2:0]  table_select,
	input  logic [15:0] address,
	input  logic [31:0] load_value,
	input  logic [9:0]  snapshot,
	input  logic [23:0] metals,
	input  logic [31:0] rate,
	input  logic [63:0] merge_in,
	input  logic [63:0] merge_out,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] in_value,
	output logic [63:0] out_value
);

	tfa_cmd_t cmd;
	tfa_sts_t sts;

	tfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tfa_dp #(
		.SNAPS          (SNAPS),
		.BANDS          (BANDS),
		.MAX_ROWS       (MAX_ROWS),
		.TEMPLATE_DEPTH (TEMPLATE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.table_select (table_select),
		.address      (address),
		.load_value   (load_value),
		.snapshot     (snapshot),
		.metals       (metals),
		.rate         (rate),
		.merge_in     (merge_in),
		.merge_out    (merge_out),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.in_value     (in_value),
		.out_value    (out_value),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

### design/tfa_ctrl.sv
// ----------------------------------------------------------------------------
// tfa_ctrl
// Sequencer of the template flux accumulator: decodes an item and steps the
// datapath through burst, merge and read work.
// ----------------------------------------------------------------------------
module tfa_ctrl
	import tfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  tfa_sts_t sts,
	output tfa_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_ROW    = 4'd2;
	localparam logic [3:0] S_CLAMP  = 4'd3;
	localparam logic [3:0] S_SNAP   = 4'd4;
	localparam logic [3:0] S_ADDR   = 4'd5;
	localparam logic [3:0] S_BRD    = 4'd6;
	localparam logic [3:0] S_BMUL   = 4'd7;
	localparam logic [3:0] S_BACC   = 4'd8;
	localparam logic [3:0] S_NEXT   = 4'd9;
	localparam logic [3:0] S_MERGE  = 4'd10;
	localparam logic [3:0] S_READ   = 4'd11;
	localparam logic [3:0] S_RESULT = 4'd12;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.command)
					CMD_CLEAR, CMD_LOAD: begin
						cmd.exec = 1'b1;
						state_d  = S_RESULT;
					end
					CMD_BURST: state_d = S_ROW;
					CMD_MERGE: begin
						cmd.flux_rd = sts.elem_ok;
						state_d     = sts.elem_ok ? S_MERGE : S_RESULT;
					end
					CMD_READ: begin
						cmd.flux_rd = sts.elem_ok;
						state_d     = sts.elem_ok ? S_READ : S_RESULT;
					end
					default: state_d = S_RESULT;
				endcase
			end
			S_ROW: begin
				cmd.row_calc = 1'b1;
				state_d      = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_SNAP;
			end
			S_SNAP: begin
				cmd.snap_fetch = 1'b1;
				state_d        = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr_calc = 1'b1;
				state_d       = sts.used ? S_BRD : S_NEXT;
			end
			S_BRD: begin
				cmd.band_rd = 1'b1;
				state_d     = S_BMUL;
			end
			S_BMUL: begin
				cmd.band_mul = 1'b1;
				state_d      = S_BACC;
			end
			S_BACC: begin
				cmd.band_acc = 1'b1;
				state_d      = sts.last_band ? S_NEXT : S_BRD;
			end
			S_NEXT: begin
				cmd.snap_next = 1'b1;
				state_d       = sts.last_snap ? S_RESULT : S_SNAP;
			end
			S_MERGE: begin
				cmd.merge_acc = 1'b1;
				state_d       = S_RESULT;
			end
			S_READ: begin
				cmd.read_cap = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/tfa_dp.sv
// ----------------------------------------------------------------------------
// tfa_dp
// Datapath: configuration, table memories, flux accumulators, row and
// address arithmetic, multiply and saturating add, output register.
// ----------------------------------------------------------------------------
module tfa_dp
	import tfa_pkg::*;
#(
	parameter int SNAPS          = SNAPS_DEF,
	parameter int BANDS          = BANDS_DEF,
	parameter int MAX_ROWS       = MAX_ROWS_DEF,
	parameter int TEMPLATE_DEPTH = TEMPLATE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  command,
	input  logic [2:0]  table_select,
	input  logic [15:0] address,
	input  logic [31:0] load_value,
	input  logic [9:0]  snapshot,
	input  logic [23:0] metals,
	input  logic [31:0] rate,
	input  logic [63:0] merge_in,
	input  logic [63:0] merge_out,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] in_value,
	output logic [63:0] out_value,
	input  tfa_cmd_t    cmd,
	output tfa_sts_t    sts
);

	localparam int ELEMS = SNAPS * BANDS;
	localparam int SPD   = SNAPS * MAX_ROWS * BANDS;
	localparam int SW    = (SNAPS > 1) ? $clog2(SNAPS) : 1;
	localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int EW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
	localparam int TW    = $clog2(TEMPLATE_DEPTH);
	localparam int SPW   = $clog2(SPD);

	// configuration
	logic [5:0]  min_row_q, max_row_q;
	logic [6:0]  row_count_q;
	logic [31:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_row_q   <= 6'd0;
			max_row_q   <= 6'd63;
			row_count_q <= 7'd64;
			floor_q     <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_ROW:   min_row_q   <= cfg_data[5:0];
				CFG_MAX_ROW:   max_row_q   <= cfg_data[5:0];
				CFG_ROW_COUNT: row_count_q <= cfg_data[6:0];
				CFG_FLOOR:     floor_q     <= cfg_data;
			endcase
		end
	end

	// latched item
	logic [2:0]  cmd_q, sel_q;
	logic [15:0] addr_q;
	logic [31:0] load_q, rate_q;
	logic [9:0]  snap_in_q;
	logic [23:0] metals_q;
	logic [63:0] min_q, mout_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q     <= command;
			sel_q     <= table_select;
			addr_q    <= address;
			load_q    <= load_value;
			snap_in_q <= snapshot;
			metals_q  <= metals;
			rate_q    <= rate;
			min_q     <= merge_in;
			mout_q    <= merge_out;
		end
	end

	logic elem_ok;
	assign elem_ok = (32'(addr_q) < ELEMS);

	// small tables
	logic [9:0] tgt_tab [SNAPS];
	logic [9:0] cloud_tab [SNAPS];

	logic load_age, load_insp, load_outsp, load_tgt, load_cloud, load_bad;
	always_comb begin
		load_age   = 1'b0;
		load_insp  = 1'b0;
		load_outsp = 1'b0;
		load_tgt   = 1'b0;
		load_cloud = 1'b0;
		load_bad   = 1'b0;
		unique case (sel_q)
			SEL_AGE:    if (32'(addr_q) < TEMPLATE_DEPTH) load_age = 1'b1;
			            else load_bad = 1'b1;
			SEL_INSP:   if (32'(addr_q) < SPD) load_insp = 1'b1; else load_bad = 1'b1;
			SEL_OUTSP:  if (32'(addr_q) < SPD) load_outsp = 1'b1; else load_bad = 1'b1;
			SEL_TARGET: if (32'(addr_q) < SNAPS) load_tgt = 1'b1; else load_bad = 1'b1;
			SEL_CLOUD:  if (32'(addr_q) < SNAPS) load_cloud = 1'b1; else load_bad = 1'b1;
			default:    load_bad = 1'b1;
		endcase
	end

	logic do_load;
	assign do_load = cmd.exec && (cmd_q == CMD_LOAD);

	always_ff @(posedge clk) begin
		if (do_load && load_tgt) begin
			tgt_tab[SW'(addr_q)] <= load_q[9:0];
		end
		if (do_load && load_cloud) begin
			cloud_tab[SW'(addr_q)] <= load_q[9:0];
		end
	end

	// burst arithmetic
	logic [33:0]   p_q;
	logic [5:0]    row_q;
	logic [SW-1:0] snap_q;
	logic [BW-1:0] band_q;
	logic [TW-1:0] base_q, woff_q;
	logic [SPW-1:0] soff_q;
	logic [9:0]    age_q, bc_q;
	logic          used_q;
	logic [15:0]   prt_q;
	logic [11:0]   spec_q;
	logic [16:0]   step_q;
	logic [9:0]    row_raw;
	logic [9:0]    tgt;

	assign row_raw = (p_q >= HALF_Q24) ? 10'((p_q - HALF_Q24) >> 24) : 10'd0;
	assign tgt     = tgt_tab[snap_q];

	always_ff @(posedge clk) begin
		if (cmd.row_calc) begin
			p_q <= 34'(metals_q) * METAL_SCALE;
		end
		if (cmd.clamp) begin
			priority if (row_raw < 10'(min_row_q)) row_q <= min_row_q;
			else if (row_raw > 10'(max_row_q))     row_q <= max_row_q;
			else                                   row_q <= row_raw[5:0];
			base_q <= '0;
			snap_q <= '0;
		end
		if (cmd.snap_fetch) begin
			used_q <= (tgt >= snap_in_q);
			age_q  <= tgt - snap_in_q;
			bc_q   <= cloud_tab[snap_q];
			prt_q  <= 16'(row_q) * 16'(tgt);
			spec_q <= 12'(snap_q) * 12'(row_count_q);
			step_q <= 17'(tgt) * 17'(row_count_q);
		end
		if (cmd.addr_calc) begin
			woff_q <= TW'(32'(base_q) + (32'(prt_q) + 32'(age_q)) * 32'(BANDS));
			soff_q <= SPW'((32'(spec_q) + 32'(row_q)) * 32'(BANDS));
			band_q <= '0;
		end
		if (cmd.band_acc) begin
			band_q <= band_q + BW'(1);
		end
		if (cmd.snap_next) begin
			base_q <= TW'(32'(base_q) + 32'(step_q) * 32'(BANDS));
			snap_q <= snap_q + SW'(1);
		end
	end

	// template and special memories, addresses wrap on the table size
	logic [31:0] tmpl_mem [TEMPLATE_DEPTH];
	logic [31:0] insp_mem [SPD];
	logic [31:0] outsp_mem [SPD];
	logic [31:0] tmpl_rd_q, insp_rd_q, outsp_rd_q;

	always_ff @(posedge clk) begin
		if (do_load && load_age) begin
			tmpl_mem[TW'(addr_q)] <= load_q;
		end
		if (cmd.band_rd) begin
			tmpl_rd_q <= tmpl_mem[woff_q + TW'(band_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (do_load && load_insp) begin
			insp_mem[SPW'(addr_q)] <= load_q;
		end
		if (cmd.band_rd) begin
			insp_rd_q <= insp_mem[soff_q + SPW'(band_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (do_load && load_outsp) begin
			outsp_mem[SPW'(addr_q)] <= load_q;
		end
		if (cmd.band_rd) begin
			outsp_rd_q <= outsp_mem[soff_q + SPW'(band_q)];
		end
	end

	logic age_eq, age_gt;
	logic [63:0] prod_a_s1, prod_b_s1;
	assign age_eq = (age_q == bc_q);
	assign age_gt = (age_q > bc_q);

	always_ff @(posedge clk) begin
		if (cmd.band_mul) begin
			prod_a_s1 <= 64'(rate_q) * 64'(age_eq ? insp_rd_q : tmpl_rd_q);
			prod_b_s1 <= 64'(rate_q) * 64'(outsp_rd_q);
		end
	end

	// flux accumulators; an entry not written since the last clear reads
	// as the floor value captured by that clear
	logic [63:0] fin_mem [ELEMS];
	logic [63:0] fout_mem [ELEMS];
	logic [63:0] fin_rd_q, fout_rd_q;
	logic        fvld_rd_q;
	logic [ELEMS-1:0] fvld_q;
	logic [31:0] clr_val_q;
	logic [EW-1:0] elem, fidx;
	logic flux_we, do_clear;
	logic [63:0] fin_cur, fout_cur, in_add, out_add, fin_new, fout_new;

	assign elem     = EW'(32'(snap_q) * 32'(BANDS) + 32'(band_q));
	assign fidx     = (cmd.band_rd || cmd.band_acc) ? elem : EW'(addr_q);
	assign flux_we  = cmd.band_acc || cmd.merge_acc;
	assign do_clear = cmd.exec && (cmd_q == CMD_CLEAR);

	always_ff @(posedge clk) begin
		if (flux_we) begin
			fin_mem[fidx]  <= fin_new;
			fout_mem[fidx] <= fout_new;
		end
		if (cmd.band_rd || cmd.flux_rd) begin
			fin_rd_q  <= fin_mem[fidx];
			fout_rd_q <= fout_mem[fidx];
			fvld_rd_q <= fvld_q[fidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q    <= '0;
			clr_val_q <= 32'd1;
		end else if (do_clear) begin
			fvld_q    <= '0;
			clr_val_q <= floor_q;
		end else if (flux_we) begin
			fvld_q[fidx] <= 1'b1;
		end
	end

	logic [64:0] in_sum, out_sum;
	logic        sat;

	assign fin_cur  = fvld_rd_q ? fin_rd_q : 64'(clr_val_q);
	assign fout_cur = fvld_rd_q ? fout_rd_q : 64'(clr_val_q);

	always_comb begin
		if (cmd.merge_acc) begin
			in_add  = min_q;
			out_add = mout_q;
		end else begin
			in_add  = age_gt ? 64'd0 : prod_a_s1;
			out_add = age_eq ? prod_b_s1 : (age_gt ? prod_a_s1 : 64'd0);
		end
	end

	assign in_sum   = 65'(fin_cur) + 65'(in_add);
	assign out_sum  = 65'(fout_cur) + 65'(out_add);
	assign fin_new  = in_sum[64] ? '1 : in_sum[63:0];
	assign fout_new = out_sum[64] ? '1 : out_sum[63:0];
	assign sat      = in_sum[64] || out_sum[64];

	// item result
	logic [1:0]  st_q;
	logic [63:0] iv_q, ov_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			st_q <= (((command == CMD_MERGE) || (command == CMD_READ))
			         && (32'(address) >= ELEMS)) ? ST_RANGE : ST_OK;
			iv_q <= '0;
			ov_q <= '0;
		end else begin
			if (do_load && load_bad) st_q <= ST_RANGE;
			if (flux_we && sat)      st_q <= ST_SAT;
			if (cmd.read_cap) begin
				iv_q <= fin_cur;
				ov_q <= fout_cur;
			end
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			status    <= st_q;
			in_value  <= iv_q;
			out_value <= ov_q;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.command   = cmd_q;
	assign sts.elem_ok   = elem_ok;
	assign sts.used      = used_q;
	assign sts.last_band = (band_q == BW'(BANDS - 1));
	assign sts.last_snap = (snap_q == SW'(SNAPS - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

### design/tfa_checker.sv
// ----------------------------------------------------------------------------
// tfa_checker
// Port-level checks of the template flux accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module tfa_checker
	import tfa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [63:0] in_value,
	input logic [63:0] out_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
		&& $stable(in_value) && $stable(out_value))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_SAT))
		else $error("bad status code");

	// only a successful read carries values
	a_values_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> in_value == 64'd0 && out_value == 64'd0)
		else $error("values on a failed item");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

endmodule

bind template_flux_accumulator tfa_checker u_tfa_checker (.*);

### sim/tfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_scoreboard
// Watches the item, result and configuration ports of the flux accumulator,
// keeps its own copy of the accumulators and tables, predicts every result
// and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module tfa_scoreboard
	import tfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  command,
	input  logic [2:0]  table_select,
	input  logic [15:0] address,
	input  logic [31:0] load_value,
	input  logic [9:0]  snapshot,
	input  logic [23:0] metals,
	input  logic [31:0] rate,
	input  logic [63:0] merge_in,
	input  logic [63:0] merge_out,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [63:0] in_value,
	input  logic [63:0] out_value,
	output int          errors,
	output int          pending
);

	localparam int NSNAP = SNAPS_DEF;
	localparam int NBAND = BANDS_DEF;
	localparam int NELEM = NSNAP * NBAND;
	localparam int SP_DEPTH = NSNAP * MAX_ROWS_DEF * NBAND;
	localparam int TPL_DEPTH = TEMPLATE_DEPTH_DEF;

	typedef struct {
		logic [1:0]  st;
		logic [63:0] iv;
		logic [63:0] ov;
	} flux_result_t;

	flux_result_t flux_results_q[$];

	logic [5:0]  min_row, max_row;
	logic [6:0]  row_count;
	logic [31:0] floor_val;
	logic [63:0] in_flux  [NELEM];
	logic [63:0] out_flux [NELEM];
	logic [31:0] age_tpl  [TPL_DEPTH];
	logic [31:0] in_spec  [SP_DEPTH];
	logic [31:0] out_spec [SP_DEPTH];
	logic [9:0]  tgt_snap [NSNAP];
	logic [9:0]  cloud_age [NSNAP];

	// bit 64 flags saturation
	function automatic logic [64:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64])
			return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
		return s;
	endfunction

	function automatic logic [63:0] metal_to_row(input logic [23:0] m);
		logic [63:0] p, r;
		p = 64'(m) * 64'd1000;
		r = (p >= 64'd8388608) ? ((p - 64'd8388608) >> 24) : 64'd0;
		if (r < 64'(min_row))
			r = 64'(min_row);
		else if (r > 64'(max_row))
			r = 64'(max_row);
		return r;
	endfunction

	task automatic fill_floor();
		for (int k = 0; k < NELEM; k++) begin
			in_flux[k]  = 64'(floor_val);
			out_flux[k] = 64'(floor_val);
		end
	endtask

	task automatic accumulate_burst(output logic sat);
		logic [63:0] row, base, t, age, woff, soff, w, si, ws;
		logic [64:0] r1;
		int e;
		sat  = 1'b0;
		row  = metal_to_row(metals);
		base = 0;
		for (int s = 0; s < NSNAP; s++) begin
			t = 64'(tgt_snap[s]);
			if (t >= 64'(snapshot)) begin
				age  = t - 64'(snapshot);
				woff = base + (row * t + age) * NBAND;
				soff = 64'(s) * 64'(row_count) * NBAND + row * NBAND;
				for (int b = 0; b < NBAND; b++) begin
					e = s * NBAND + b;
					if (age == 64'(cloud_age[s])) begin
						si = (soff + 64'(b)) % SP_DEPTH;
						r1 = sat_sum(in_flux[e], 64'(rate) * 64'(in_spec[si]));
						in_flux[e] = r1[63:0];
						sat |= r1[64];
						r1 = sat_sum(out_flux[e], 64'(rate) * 64'(out_spec[si]));
						out_flux[e] = r1[63:0];
						sat |= r1[64];
					end else begin
						ws = (woff + 64'(b)) % TPL_DEPTH;
						w  = 64'(age_tpl[ws]);
						if (age > 64'(cloud_age[s])) begin
							r1 = sat_sum(out_flux[e], 64'(rate) * w);
							out_flux[e] = r1[63:0];
						end else begin
							r1 = sat_sum(in_flux[e], 64'(rate) * w);
							in_flux[e] = r1[63:0];
						end
						sat |= r1[64];
					end
				end
			end
			base += t * 64'(row_count) * NBAND;
		end
	endtask

	task automatic predict_item();
		flux_result_t r;
		logic sat;
		logic [64:0] r1, r2;
		r = '{st: ST_OK, iv: 64'd0, ov: 64'd0};
		case (command)
			CMD_CLEAR: fill_floor();
			CMD_LOAD: begin
				case (table_select)
					SEL_AGE: age_tpl[address] = load_value;
					SEL_INSP, SEL_OUTSP: begin
						if (address >= SP_DEPTH)
							r.st = ST_RANGE;
						else if (table_select == SEL_INSP)
							in_spec[address] = load_value;
						else
							out_spec[address] = load_value;
					end
					SEL_TARGET, SEL_CLOUD: begin
						if (address >= NSNAP)
							r.st = ST_RANGE;
						else if (table_select == SEL_TARGET)
							tgt_snap[address] = load_value[9:0];
						else
							cloud_age[address] = load_value[9:0];
					end
					default: r.st = ST_RANGE;
				endcase
			end
			CMD_BURST: begin
				accumulate_burst(sat);
				if (sat)
					r.st = ST_SAT;
			end
			CMD_MERGE: begin
				if (address >= NELEM) begin
					r.st = ST_RANGE;
				end else begin
					r1 = sat_sum(in_flux[address], merge_in);
					r2 = sat_sum(out_flux[address], merge_out);
					in_flux[address]  = r1[63:0];
					out_flux[address] = r2[63:0];
					if (r1[64] || r2[64])
						r.st = ST_SAT;
				end
			end
			CMD_READ: begin
				if (address >= NELEM) begin
					r.st = ST_RANGE;
				end else begin
					r.iv = in_flux[address];
					r.ov = out_flux[address];
				end
			end
			default: ;
		endcase
		flux_results_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		flux_result_t e;
		if (!arst_n) begin
			min_row   = 6'd0;
			max_row   = 6'd63;
			row_count = 7'd64;
			floor_val = 32'd1;
			fill_floor();
			flux_results_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (flux_results_q.size() == 0) begin
					$display("%0t: result with no item waiting: status %0d", $time, status);
					errors <= errors + 1;
				end else begin
					e = flux_results_q.pop_front();
					if (e.st !== status || e.iv !== in_value || e.ov !== out_value) begin
						$display("%0t: status exp %0d act %0d", $time, e.st, status);
						$display("%0t: in_value exp %h act %h", $time, e.iv, in_value);
						$display("%0t: out_value exp %h act %h", $time, e.ov, out_value);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_ROW:   min_row   = cfg_data[5:0];
					CFG_MAX_ROW:   max_row   = cfg_data[5:0];
					CFG_ROW_COUNT: row_count = cfg_data[6:0];
					CFG_FLOOR:     floor_val = cfg_data;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item();
			pending <= flux_results_q.size();
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, load, burst, merge and read items into the flux accumulator
// under random idling on both channels and several register settings; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import tfa_pkg::*;

	localparam int NSNAP = SNAPS_DEF;
	localparam int NBAND = BANDS_DEF;
	localparam int SP_DEPTH = NSNAP * MAX_ROWS_DEF * NBAND;
	localparam int TPL_DEPTH = TEMPLATE_DEPTH_DEF;
	localparam int NUM_ITEMS = 1150;
	localparam int QUIET_FROM = 1000;
	localparam int WATCHDOG = 20000;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_stall;
	logic [2:0]  command, table_select;
	logic [15:0] address;
	logic [31:0] load_value;
	logic [9:0]  snapshot;
	logic [23:0] metals;
	logic [31:0] rate;
	logic [63:0] merge_in, merge_out;
	logic        out_valid, out_stall;
	logic [1:0]  status;
	logic [63:0] in_value, out_value;
	int          errors, pending;

	// stimulus-side view of what the block holds, to keep bursts on loaded words
	logic [5:0]  cur_min, cur_max;
	logic [6:0]  cur_rows;
	logic [9:0]  cur_tgt [NSNAP];
	logic [9:0]  cur_cloud [NSNAP];
	bit          tpl_loaded [TPL_DEPTH];
	bit          in_sp_loaded [SP_DEPTH];
	bit          out_sp_loaded [SP_DEPTH];
	int          sent;
	bit          quiet;
	int          stall_left, idle_cycles;

	template_flux_accumulator u_dut (.*);

	tfa_scoreboard u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stalls in bursts, with calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (quiet || (sent / 90) % 3 == 2) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 6) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input logic [2:0] c, input logic [2:0] sel, input logic [15:0] a,
			input logic [31:0] lv, input logic [9:0] sn, input logic [23:0] mt,
			input logic [31:0] rt, input logic [63:0] mi, input logic [63:0] mo);
		command <= c; table_select <= sel; address <= a; load_value <= lv;
		snapshot <= sn; metals <= mt; rate <= rt; merge_in <= mi; merge_out <= mo;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (c == CMD_LOAD) begin
			if (sel == SEL_AGE)
				tpl_loaded[a] = 1'b1;
			else if (sel == SEL_INSP && a < SP_DEPTH)
				in_sp_loaded[a] = 1'b1;
			else if (sel == SEL_OUTSP && a < SP_DEPTH)
				out_sp_loaded[a] = 1'b1;
			else if (sel == SEL_TARGET && a < NSNAP)
				cur_tgt[a] = lv[9:0];
			else if (sel == SEL_CLOUD && a < NSNAP)
				cur_cloud[a] = lv[9:0];
		end
		if (!quiet && (sent / 70) % 3 != 1 && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic load(input logic [2:0] sel, input logic [15:0] a, input logic [31:0] v);
		send(CMD_LOAD, sel, a, v, $urandom, $urandom, $urandom, rnd64(), rnd64());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_MIN_ROW:   cur_min  = v[5:0];
			CFG_MAX_ROW:   cur_max  = v[5:0];
			CFG_ROW_COUNT: cur_rows = v[6:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [5:0] mn, input logic [5:0] mx, input logic [6:0] rc,
			input logic [31:0] fl);
		drain();
		cfg_write(CFG_MIN_ROW, mn);
		cfg_write(CFG_MAX_ROW, mx);
		cfg_write(CFG_ROW_COUNT, rc);
		cfg_write(CFG_FLOOR, fl);
	endtask

	// loads every table word the burst will touch that is still unwritten
	task automatic burst(input logic [9:0] sn, input logic [23:0] mt, input logic [31:0] rt);
		logic [63:0] p, row, base, t, age, woff, soff, ad;
		p = 64'(mt) * 64'd1000;
		row = (p >= 64'd8388608) ? ((p - 64'd8388608) >> 24) : 64'd0;
		if (row < 64'(cur_min))
			row = 64'(cur_min);
		else if (row > 64'(cur_max))
			row = 64'(cur_max);
		base = 0;
		for (int s = 0; s < NSNAP; s++) begin
			t = 64'(cur_tgt[s]);
			if (t >= 64'(sn)) begin
				age  = t - 64'(sn);
				woff = base + (row * t + age) * NBAND;
				soff = 64'(s) * 64'(cur_rows) * NBAND + row * NBAND;
				for (int b = 0; b < NBAND; b++) begin
					if (age == 64'(cur_cloud[s])) begin
						ad = (soff + 64'(b)) % SP_DEPTH;
						if (!in_sp_loaded[ad])
							load(SEL_INSP, ad[15:0], $urandom);
						if (!out_sp_loaded[ad])
							load(SEL_OUTSP, ad[15:0], $urandom);
					end else begin
						ad = (woff + 64'(b)) % TPL_DEPTH;
						if (!tpl_loaded[ad])
							load(SEL_AGE, ad[15:0], $urandom);
					end
				end
			end
			base += t * 64'(cur_rows) * NBAND;
		end
		send(CMD_BURST, $urandom, $urandom, $urandom, sn, mt, rt, rnd64(), rnd64());
	endtask

	initial begin
		int pick;
		logic [31:0] rt;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; command = '0; table_select = '0; address = '0;
		load_value = '0; snapshot = '0; metals = '0; rate = '0;
		merge_in = '0; merge_out = '0;
		cur_min = 6'd0; cur_max = 6'd63; cur_rows = 7'd64;
		sent = 0; quiet = 1'b0; idle_cycles = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// reset values of the accumulators, then the snapshot tables
		send(CMD_READ, $urandom, 16'd0, $urandom, $urandom, $urandom, $urandom, rnd64(), rnd64());
		configure(6'd0, 6'd3, 7'd4, 32'd5);
		for (int s = 0; s < NSNAP; s++) begin
			load(SEL_TARGET, 16'(s), {22'h3F_FFFF, 10'(s + 2)});
			load(SEL_CLOUD, 16'(s), $urandom_range(0, 3));
		end

		// directed corner items
		send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, rnd64(), rnd64());
		load(SEL_INSP, 16'd8192, $urandom);
		load(SEL_TARGET, 16'd8, $urandom);
		load(3'd5, 16'd0, $urandom);
		load(3'd7, 16'hFFFF, $urandom);
		load(SEL_AGE, 16'hFFFF, 32'hFFFF_FFFF);
		burst(10'd0, 24'd0, 32'hFFFF_FFFF);
		burst(10'd3, 24'hFF_FFFF, 32'd0);
		burst(10'd1023, 24'd8389, 32'h0001_0000);
		send(CMD_MERGE, 0, 16'd127, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send(CMD_MERGE, 0, 16'd128, 0, 0, 0, 0, rnd64(), rnd64());
		send(CMD_READ, 0, 16'd127, 0, 0, 0, 0, 0, 0);
		send(CMD_READ, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		send(3'd5, 0, 0, 0, 0, 0, 0, 0, 0);
		send(3'd7, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 24'hFF_FFFF, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

		// min above max, a row count of MAX_ROWS and the top floor; then one row and a zero floor
		configure(6'd63, 6'd0, 7'd64, 32'hFFFF_FFFF);
		send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		burst(10'd2, 24'h12_3456, 32'h0000_0003);
		send(CMD_READ, 0, 16'd5, 0, 0, 0, 0, 0, 0);
		configure(6'd0, 6'd63, 7'd1, 32'd0);
		send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		burst(10'd2, 24'd100000, 32'h0000_0100);
		send(CMD_READ, 0, 16'd40, 0, 0, 0, 0, 0, 0);

		while (sent < NUM_ITEMS) begin
			if (sent >= QUIET_FROM)
				quiet = 1'b1;
			if (sent % 200 < 3 && sent > 100) begin
				configure($urandom_range(0, 2), $urandom_range(1, 5), $urandom_range(1, 8),
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000));
				send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					rnd64(), rnd64());
			end
			pick = $urandom_range(0, 99);
			rt = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
			if (pick < 38) begin
				burst($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 12),
					$urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 70000), rt);
			end else if (pick < 63) begin
				send(CMD_READ, $urandom, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 127),
					$urandom, $urandom, $urandom, $urandom, rnd64(), rnd64());
			end else if (pick < 73) begin
				send(CMD_MERGE, $urandom,
					$urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 127),
					$urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 2) == 0 ? rnd64() : 64'($urandom),
					$urandom_range(0, 2) == 0 ? rnd64() : 64'($urandom));
			end else if (pick < 88) begin
				case ($urandom_range(0, 5))
					0: load(SEL_AGE, $urandom, $urandom);
					1: load(SEL_INSP, $urandom_range(0, 9000), $urandom);
					2: load(SEL_OUTSP, $urandom_range(0, 9000), $urandom);
					3: load(SEL_TARGET, $urandom_range(0, 9),
						$urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 12));
					4: load(SEL_CLOUD, $urandom_range(0, 9),
						$urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 6));
					default: load($urandom_range(5, 7), $urandom, $urandom);
				endcase
			end else if (pick < 95) begin
				send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					rnd64(), rnd64());
			end else begin
				send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, rnd64(), rnd64());
			end
			// sender holds off until everything is back
			if (sent % 250 == 125)
				drain();
		end

		drain();
		repeat (500) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
